// ===== sv/tfdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-fluid density relaxation package
// Shared constants, register codes and latency helpers for the relaxation
// datapath.
// ----------------------------------------------------------------------------
package tfdr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MUL_CHUNK = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ELC_MASS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ION_MASS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_GAMMA = 2'd2;

    localparam logic [31:0] ELC_MASS_RST = 32'd2621;
    localparam logic [31:0] ION_MASS_RST = 32'd65536;

    // Stages of the chunked multiplier for a second operand of bw bits.
    function automatic int mul_lat(input int bw);
        return (bw + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

    // Cycles from the new mass density to the finished species result.
    function automatic int sp_lat(input int w);
        return mul_lat(w - 1) + mul_lat(w) + 4 * w + 1;
    endfunction

endpackage

// ===== sv/tfdr_dly.sv =====
// ----------------------------------------------------------------------------
// Delay line
// Shift register that carries side data alongside the arithmetic stages.
// ----------------------------------------------------------------------------
module tfdr_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1,
    parameter bit CLR   = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (CLR && !i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_sr[i] <= '0;
            end
        end else if (i_en) begin
            r_sr[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_sr[i] <= r_sr[i-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

// ===== sv/tfdr_mul.sv =====
// ----------------------------------------------------------------------------
// Pipelined multiplier
// Unsigned product built from one 16-bit slice of the second operand per
// stage, accumulated down the pipeline.
// ----------------------------------------------------------------------------
module tfdr_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int CW = tfdr_pkg::MUL_CHUNK;
    localparam int NS = tfdr_pkg::mul_lat(BW);
    localparam int PW = NS * CW;
    localparam int RW = AW + BW;
    localparam int EW = AW + PW;

    logic [AW-1:0] r_a [NS-1];
    logic [PW-1:0] r_b [NS-1];
    logic [RW-1:0] r_p [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [AW-1:0]    a_in;
            logic [PW-1:0]    b_in;
            logic [RW-1:0]    p_in;
            logic [AW+CW-1:0] pp;
            logic [EW-1:0]    pp_sh;

            if (k == 0) begin : g_first
                assign a_in = i_a;
                assign b_in = PW'(i_b);
                assign p_in = '0;
            end else begin : g_next
                assign a_in = r_a[k-1];
                assign b_in = r_b[k-1];
                assign p_in = r_p[k-1];
            end

            assign pp    = (AW+CW)'(a_in) * (AW+CW)'(b_in[k*CW +: CW]);
            assign pp_sh = EW'(pp) << (k * CW);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[k] <= p_in + RW'(pp_sh);
                end
            end

            if (k < NS - 1) begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_a[k] <= a_in;
                        r_b[k] <= b_in;
                    end
                end
            end
        end
    endgenerate

    assign o_p = r_p[NS-1];

endmodule

// ===== sv/tfdr_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring unsigned division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfdr_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_q   [NW];
    logic [DW-1:0] r_d   [NW-1];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [DW-1:0] d_in;
            logic [NW-1:0] q_in;
            logic [DW:0]   t;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign q_in   = i_num;
                assign d_in   = i_den;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign q_in   = r_q[k-1];
                assign d_in   = r_d[k-1];
            end

            // The numerator shifts out at the top while quotient bits enter below.
            assign t    = {rem_in, q_in[NW-1]};
            assign ge   = (t >= {1'b0, d_in});
            assign diff = t - {1'b0, d_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
                    r_q[k]   <= {q_in[NW-2:0], ge};
                end
            end

            if (k < NW - 1) begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_d[k] <= d_in;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_q[NW-1];

endmodule

// ===== sv/tfdr_species.sv =====
// ----------------------------------------------------------------------------
// Species relaxation datapath
// Rescales one species' momenta to its new density and rebuilds its energy
// so that the internal energy is kept.
// ----------------------------------------------------------------------------
module tfdr_species #(
    parameter int DATA_WIDTH = 32,
    parameter int NR_LAT     = 51
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [DATA_WIDTH-2:0]        i_rho,
    input  logic [DATA_WIDTH-2:0]        i_eng,
    input  logic [DATA_WIDTH-1:0]        i_mag [3],
    input  logic                         i_neg [3],
    input  logic [DATA_WIDTH-2:0]        i_new_rho,
    output logic [DATA_WIDTH-2:0]        o_rho,
    output logic signed [DATA_WIDTH-1:0] o_mom [3],
    output logic [DATA_WIDTH-2:0]        o_eng
);

    localparam int W   = DATA_WIDTH;
    localparam int U   = W - 1;
    localparam int LMU = tfdr_pkg::mul_lat(U);
    localparam int LMW = tfdr_pkg::mul_lat(W);
    localparam int T2  = NR_LAT + LMU;
    localparam int T3  = T2 + 2 * W - 1;
    localparam int T4  = T3 + 1;
    localparam int T5  = T4 + LMW;
    localparam int T6  = T5 + 1;
    localparam int T7  = T6 + 2 * W;
    localparam int TS  = LMW + 1;
    localparam int TK0 = TS + 2 * W;
    localparam int TK  = TK0 + 1;
    localparam logic [2*W-2:0] SIGN_Q = (2*W-1)'(1) << (W - 1);
    localparam logic [2*W-2:0] SMAX_Q = SIGN_Q - (2*W-1)'(1);

    // Kinetic energy of the incoming state.
    logic [2*W-1:0] sq0 [3];
    logic [2*W-1:0] r_sum0;
    logic [U-1:0]   rho_ts;
    logic [2*W-1:0] ke;
    logic [U-1:0]   eng_k;
    logic [2*W:0]   r_eint;
    logic [2*W:0]   eint_d;

    // Rescaled momenta and their kinetic energy.
    logic [W-1:0]          mag_d  [3];
    logic                  neg_d  [3];
    logic [W+U-1:0]        rp     [3];
    logic [U-1:0]          rho_t2;
    logic [W+U-1:0]        quo    [3];
    logic signed [W-1:0]   r_nm   [3];
    logic [W-1:0]          r_nmag [3];
    logic [2*W-1:0]        sq1    [3];
    logic [2*W-1:0]        r_sum1;
    logic [U-1:0]          nr_t6;
    logic [U-1:0]          nr_t7;
    logic [2*W-1:0]        ke2_q;
    logic [2*W-1:0]        ke2;
    logic signed [2*W:0]   e2;

    tfdr_dly #(.WIDTH(U), .DEPTH(TS)) u_rho_ts (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(i_rho), .o_q(rho_ts)
    );
    tfdr_dly #(.WIDTH(U), .DEPTH(TK0)) u_eng_k (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(i_eng), .o_q(eng_k)
    );
    tfdr_dly #(.WIDTH(U), .DEPTH(T2)) u_rho_t2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(i_rho), .o_q(rho_t2)
    );
    tfdr_dly #(.WIDTH(U), .DEPTH(T6 - NR_LAT)) u_nr_t6 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(i_new_rho), .o_q(nr_t6)
    );
    tfdr_dly #(.WIDTH(U), .DEPTH(T7 - T6)) u_nr_t7 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(nr_t6), .o_q(nr_t7)
    );
    tfdr_dly #(.WIDTH(2*W+1), .DEPTH(T7 - TK)) u_eint (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(r_eint), .o_q(eint_d)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            logic [W-1:0] cap;
            logic [W-1:0] nm_d;

            tfdr_mul #(.AW(W), .BW(W)) u_sq0 (
                .i_clk(i_clk), .i_en(i_en), .i_a(i_mag[c]), .i_b(i_mag[c]), .o_p(sq0[c])
            );
            tfdr_dly #(.WIDTH(W), .DEPTH(NR_LAT)) u_mag (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(i_mag[c]),
                .o_q(mag_d[c])
            );
            tfdr_dly #(.WIDTH(1), .DEPTH(T3)) u_neg (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(i_neg[c]),
                .o_q(neg_d[c])
            );
            tfdr_mul #(.AW(W), .BW(U)) u_scale (
                .i_clk(i_clk), .i_en(i_en), .i_a(mag_d[c]), .i_b(i_new_rho), .o_p(rp[c])
            );
            tfdr_div #(.NW(W+U), .DW(U)) u_div (
                .i_clk(i_clk), .i_en(i_en), .i_num(rp[c]), .i_den(rho_t2), .o_quo(quo[c])
            );

            // A negative result may reach one step further than a positive one.
            always_comb begin
                if (neg_d[c]) begin
                    cap = (quo[c] > SIGN_Q) ? SIGN_Q[W-1:0] : quo[c][W-1:0];
                end else begin
                    cap = (quo[c] > SMAX_Q) ? SMAX_Q[W-1:0] : quo[c][W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nmag[c] <= cap;
                    r_nm[c]   <= neg_d[c] ? $signed(W'(0) - cap) : $signed(cap);
                end
            end

            tfdr_mul #(.AW(W), .BW(W)) u_sq1 (
                .i_clk(i_clk), .i_en(i_en), .i_a(r_nmag[c]), .i_b(r_nmag[c]), .o_p(sq1[c])
            );
            tfdr_dly #(.WIDTH(W), .DEPTH(T7 - T4)) u_nm (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(r_nm[c]), .o_q(nm_d)
            );
            assign o_mom[c] = $signed(nm_d);
        end
    endgenerate

    tfdr_div #(.NW(2*W), .DW(W)) u_ke (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_sum0), .i_den({rho_ts, 1'b0}), .o_quo(ke)
    );
    tfdr_div #(.NW(2*W), .DW(W)) u_ke2 (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_sum1), .i_den({nr_t6, 1'b0}), .o_quo(ke2_q)
    );

    // Three squares of at most 2^(2W-2) each fit in 2W bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum0 <= sq0[0] + sq0[1] + sq0[2];
            r_sum1 <= sq1[0] + sq1[1] + sq1[2];
            r_eint <= (2*W+1)'(eng_k) - (2*W+1)'(ke);
        end
    end

    assign ke2 = (nr_t7 == '0) ? '0 : ke2_q;
    assign e2  = $signed(eint_d) + $signed((2*W+1)'(ke2));

    always_comb begin
        if (e2 < 0) begin
            o_eng = '0;
        end else if (e2 > $signed((2*W+1)'({U{1'b1}}))) begin
            o_eng = '1;
        end else begin
            o_eng = e2[U-1:0];
        end
    end

    assign o_rho = nr_t7;

endmodule

// ===== sv/two_fluid_density_relax.sv =====
// The depth of the pipeline is set by the chain of one-bit-per-stage dividers.
// Throughput: one cell per cycle; the whole pipeline holds while a result beat
// waits on the output.
// Reset clears the valid bits and loads the default species masses.
// ----------------------------------------------------------------------------
// Two-fluid density relaxation
// Relaxes electron and ion number densities to their mean per grid cell and
// rebuilds momenta and energies around the new densities.
// ----------------------------------------------------------------------------
module two_fluid_density_relax #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tfdr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_WIDTH-2:0]              i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [DATA_WIDTH-2:0]              i_elc_density,
    input  logic signed [DATA_WIDTH-1:0]       i_elc_mom_x,
    input  logic signed [DATA_WIDTH-1:0]       i_elc_mom_y,
    input  logic signed [DATA_WIDTH-1:0]       i_elc_mom_z,
    input  logic [DATA_WIDTH-2:0]              i_elc_energy,
    input  logic [DATA_WIDTH-2:0]              i_ion_density,
    input  logic signed [DATA_WIDTH-1:0]       i_ion_mom_x,
    input  logic signed [DATA_WIDTH-1:0]       i_ion_mom_y,
    input  logic signed [DATA_WIDTH-1:0]       i_ion_mom_z,
    input  logic [DATA_WIDTH-2:0]              i_ion_energy,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [DATA_WIDTH-2:0]              o_new_elc_density,
    output logic signed [DATA_WIDTH-1:0]       o_new_elc_mom_x,
    output logic signed [DATA_WIDTH-1:0]       o_new_elc_mom_y,
    output logic signed [DATA_WIDTH-1:0]       o_new_elc_mom_z,
    output logic [DATA_WIDTH-2:0]              o_new_elc_energy,
    output logic [DATA_WIDTH-2:0]              o_new_ion_density,
    output logic signed [DATA_WIDTH-1:0]       o_new_ion_mom_x,
    output logic signed [DATA_WIDTH-1:0]       o_new_ion_mom_y,
    output logic signed [DATA_WIDTH-1:0]       o_new_ion_mom_z,
    output logic [DATA_WIDTH-2:0]              o_new_ion_energy,
    output logic                               o_bad_density
);

    localparam int W     = DATA_WIDTH;
    localparam int U     = W - 1;
    localparam int F     = tfdr_pkg::FRAC_BITS;
    localparam int NW0   = U + F;
    localparam int LMU   = tfdr_pkg::mul_lat(U);
    localparam int T1    = NW0 + 2 + LMU;
    localparam int T7    = T1 + tfdr_pkg::sp_lat(W);
    localparam int RAW_W = 2 * U + 3 * W;

    logic en;

    // Configuration.
    logic [U-1:0] r_me;
    logic [U-1:0] r_mi;
    logic [U-1:0] n_mass;

    // Input stage.
    logic                r_s0_valid;
    logic                r_s0_bad;
    logic [U-1:0]        r_rho   [2];
    logic [U-1:0]        r_eng   [2];
    logic signed [W-1:0] r_mom   [2][3];
    logic [W-1:0]        r_mag   [2][3];
    logic signed [W-1:0] mom_in  [2][3];
    logic [U-1:0]        rho_in  [2];
    logic [U-1:0]        eng_in  [2];

    // Density relaxation.
    logic [NW0-1:0]   num_dens [2];
    logic [NW0-1:0]   r_relax;
    logic [NW0+U-1:0] prod     [2];
    logic [U-1:0]     r_nr     [2];

    // Species results and bypass.
    logic [U-1:0]        sp_rho [2];
    logic signed [W-1:0] sp_mom [2][3];
    logic [U-1:0]        sp_eng [2];
    logic [RAW_W-1:0]    raw_d  [2];
    logic                valid_d;
    logic                bad_d;

    // Output register.
    logic                r_out_valid;
    logic                r_out_bad;
    logic [U-1:0]        r_out_rho [2];
    logic signed [W-1:0] r_out_mom [2][3];
    logic [U-1:0]        r_out_eng [2];

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign n_mass = (i_cfg_data == '0) ? U'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_me <= U'(tfdr_pkg::ELC_MASS_RST);
            r_mi <= U'(tfdr_pkg::ION_MASS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tfdr_pkg::REG_ELC_MASS: r_me <= n_mass;
                tfdr_pkg::REG_ION_MASS: r_mi <= n_mass;
                // The adiabatic index cancels out of the kept pressure.
                tfdr_pkg::REG_GAS_GAMMA: ;
                default: ;
            endcase
        end
    end

    assign rho_in[0]    = i_elc_density;
    assign eng_in[0]    = i_elc_energy;
    assign mom_in[0][0] = i_elc_mom_x;
    assign mom_in[0][1] = i_elc_mom_y;
    assign mom_in[0][2] = i_elc_mom_z;
    assign rho_in[1]    = i_ion_density;
    assign eng_in[1]    = i_ion_energy;
    assign mom_in[1][0] = i_ion_mom_x;
    assign mom_in[1][1] = i_ion_mom_y;
    assign mom_in[1][2] = i_ion_mom_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_bad <= (i_elc_density == '0) || (i_ion_density == '0);
            for (int s = 0; s < 2; s++) begin
                r_rho[s] <= rho_in[s];
                r_eng[s] <= eng_in[s];
                for (int c = 0; c < 3; c++) begin
                    r_mom[s][c] <= mom_in[s][c];
                    r_mag[s][c] <= mom_in[s][c][W-1] ? W'((~mom_in[s][c]) + W'(1))
                                                     : W'(mom_in[s][c]);
                end
            end
        end
    end

    tfdr_div #(.NW(NW0), .DW(U)) u_ne (
        .i_clk(i_clk), .i_en(en), .i_num({r_rho[0], F'(0)}), .i_den(r_me),
        .o_quo(num_dens[0])
    );
    tfdr_div #(.NW(NW0), .DW(U)) u_ni (
        .i_clk(i_clk), .i_en(en), .i_num({r_rho[1], F'(0)}), .i_den(r_mi),
        .o_quo(num_dens[1])
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_relax <= NW0'(((NW0+1)'(num_dens[0]) + (NW0+1)'(num_dens[1])) >> 1);
        end
    end

    tfdr_mul #(.AW(NW0), .BW(U)) u_me (
        .i_clk(i_clk), .i_en(en), .i_a(r_relax), .i_b(r_me), .o_p(prod[0])
    );
    tfdr_mul #(.AW(NW0), .BW(U)) u_mi (
        .i_clk(i_clk), .i_en(en), .i_a(r_relax), .i_b(r_mi), .o_p(prod[1])
    );

    // Mass density is the product without its fraction, saturated.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < 2; s++) begin
                r_nr[s] <= (|prod[s][NW0+U-1:F+U]) ? {U{1'b1}} : prod[s][F+U-1:F];
            end
        end
    end

    genvar s;
    generate
        for (s = 0; s < 2; s++) begin : g_sp
            logic [W-1:0] mag_s [3];
            logic         neg_s [3];
            logic [W-1:0] raw_m [3];

            for (genvar c = 0; c < 3; c++) begin : g_c
                assign mag_s[c]     = r_mag[s][c];
                assign neg_s[c]     = r_mom[s][c][W-1];
                assign raw_m[c]     = raw_d[s][2*U+c*W +: W];
            end

            tfdr_species #(.DATA_WIDTH(W), .NR_LAT(T1)) u_species (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (en),
                .i_rho     (r_rho[s]),
                .i_eng     (r_eng[s]),
                .i_mag     (mag_s),
                .i_neg     (neg_s),
                .i_new_rho (r_nr[s]),
                .o_rho     (sp_rho[s]),
                .o_mom     (sp_mom[s]),
                .o_eng     (sp_eng[s])
            );

            tfdr_dly #(.WIDTH(RAW_W), .DEPTH(T7)) u_raw (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                .i_d({r_mom[s][2], r_mom[s][1], r_mom[s][0], r_eng[s], r_rho[s]}),
                .o_q(raw_d[s])
            );

            // A cell with a zero density leaves unchanged.
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (bad_d) begin
                        r_out_rho[s] <= raw_d[s][U-1:0];
                        r_out_eng[s] <= raw_d[s][2*U-1:U];
                        for (int c = 0; c < 3; c++) begin
                            r_out_mom[s][c] <= $signed(raw_m[c]);
                        end
                    end else begin
                        r_out_rho[s] <= sp_rho[s];
                        r_out_eng[s] <= sp_eng[s];
                        for (int c = 0; c < 3; c++) begin
                            r_out_mom[s][c] <= sp_mom[s][c];
                        end
                    end
                end
            end
        end
    endgenerate

    tfdr_dly #(.WIDTH(1), .DEPTH(T7), .CLR(1'b1)) u_valid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_s0_valid), .o_q(valid_d)
    );
    tfdr_dly #(.WIDTH(1), .DEPTH(T7)) u_bad (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_s0_bad), .o_q(bad_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= valid_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bad <= bad_d;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_bad_density     = r_out_bad;
    assign o_new_elc_density = r_out_rho[0];
    assign o_new_elc_energy  = r_out_eng[0];
    assign o_new_elc_mom_x   = r_out_mom[0][0];
    assign o_new_elc_mom_y   = r_out_mom[0][1];
    assign o_new_elc_mom_z   = r_out_mom[0][2];
    assign o_new_ion_density = r_out_rho[1];
    assign o_new_ion_energy  = r_out_eng[1];
    assign o_new_ion_mom_x   = r_out_mom[1][0];
    assign o_new_ion_mom_y   = r_out_mom[1][1];
    assign o_new_ion_mom_z   = r_out_mom[1][2];

endmodule

// ===== verif/two_fluid_density_relax_tb.sv =====
// ----------------------------------------------------------------------------
// Two-fluid density relaxation testbench
// Streams grid cells through the relaxation pipeline under random idling on
// both sides, predicts each result beat in fixed point or takes it as given,
// and compares the beats field by field, in order, over several mass settings.
// ----------------------------------------------------------------------------
module two_fluid_density_relax_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 32;
    localparam int LATENCY = 185;
    localparam longint UMAX = 64'h7FFF_FFFF;
    localparam longint SMAX = 64'h7FFF_FFFF;
    localparam longint SMIN = -64'h8000_0000;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DW-2:0] rho;
        logic [DW-1:0] mx;
        logic [DW-1:0] my;
        logic [DW-1:0] mz;
        logic [DW-2:0] en;
    } t_species;

    typedef struct packed {
        t_species elc;
        t_species ion;
    } t_cell;

    typedef struct packed {
        t_cell    c;
        logic     bad;
    } t_relaxed;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tfdr_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DW-2:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_out_ready = 1'b0;
    logic o_out_valid;
    t_cell cell_in = '0;
    wire t_cell cell_out;
    logic o_bad_density;

    always #10 i_clk = ~i_clk;

    two_fluid_density_relax #(.DATA_WIDTH(DW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_elc_density(cell_in.elc.rho), .i_elc_mom_x(cell_in.elc.mx),
        .i_elc_mom_y(cell_in.elc.my), .i_elc_mom_z(cell_in.elc.mz),
        .i_elc_energy(cell_in.elc.en),
        .i_ion_density(cell_in.ion.rho), .i_ion_mom_x(cell_in.ion.mx),
        .i_ion_mom_y(cell_in.ion.my), .i_ion_mom_z(cell_in.ion.mz),
        .i_ion_energy(cell_in.ion.en),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_new_elc_density(cell_out.elc.rho), .o_new_elc_mom_x(cell_out.elc.mx),
        .o_new_elc_mom_y(cell_out.elc.my), .o_new_elc_mom_z(cell_out.elc.mz),
        .o_new_elc_energy(cell_out.elc.en),
        .o_new_ion_density(cell_out.ion.rho), .o_new_ion_mom_x(cell_out.ion.mx),
        .o_new_ion_mom_y(cell_out.ion.my), .o_new_ion_mom_z(cell_out.ion.mz),
        .o_new_ion_energy(cell_out.ion.en),
        .o_bad_density(o_bad_density)
    );

    // Predictor copy of the mass registers.
    longint unsigned elc_mass_q, ion_mass_q;

    t_relaxed pending_cells[$];
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int bad_seen = 0;
    longint cycles = 0;
    bit idle_off = 0;
    bit long_hold = 0;

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned mom_energy2(longint a, longint b, longint c);
        return abs64(a) * abs64(a) + abs64(b) * abs64(b) + abs64(c) * abs64(c);
    endfunction

    function automatic longint unsigned mass_density(longint unsigned n,
                                                     longint unsigned m);
        longint unsigned bound;
        bound = ((UMAX + 1) << tfdr_pkg::FRAC_BITS) - 1;
        if (n > bound / m) return UMAX;
        return (n * m) >> tfdr_pkg::FRAC_BITS;
    endfunction

    function automatic longint scale_mom(longint v, longint unsigned nr,
                                         longint unsigned r);
        longint unsigned q;
        q = abs64(v) * nr / r;
        if (v < 0) return (q > 64'h8000_0000) ? SMIN : -longint'(q);
        return (q > SMAX) ? SMAX : longint'(q);
    endfunction

    function automatic t_species relax_species(t_species s, longint unsigned nr);
        t_species o;
        longint m0, m1, m2, n0, n1, n2, eint, e2;
        longint unsigned r, ke, ke2;
        r = s.rho;
        m0 = longint'(signed'(s.mx));
        m1 = longint'(signed'(s.my));
        m2 = longint'(signed'(s.mz));
        ke = mom_energy2(m0, m1, m2) / (2 * r);
        eint = longint'({33'd0, s.en}) - longint'(ke);
        n0 = scale_mom(m0, nr, r);
        n1 = scale_mom(m1, nr, r);
        n2 = scale_mom(m2, nr, r);
        ke2 = (nr == 0) ? 0 : mom_energy2(n0, n1, n2) / (2 * nr);
        e2 = eint + longint'(ke2);
        if (e2 < 0) e2 = 0;
        if (e2 > longint'(UMAX)) e2 = UMAX;
        o.rho = nr[DW-2:0];
        o.mx = n0[DW-1:0];
        o.my = n1[DW-1:0];
        o.mz = n2[DW-1:0];
        o.en = e2[DW-2:0];
        return o;
    endfunction

    function automatic t_relaxed relax_cell(t_cell c);
        t_relaxed r;
        longint unsigned me, mi, ne, ni, mean;
        me = elc_mass_q ? elc_mass_q : 1;
        mi = ion_mass_q ? ion_mass_q : 1;
        if (c.elc.rho == 0 || c.ion.rho == 0) begin
            r.c = c;
            r.bad = 1'b1;
            return r;
        end
        ne = (longint'(c.elc.rho) << tfdr_pkg::FRAC_BITS) / me;
        ni = (longint'(c.ion.rho) << tfdr_pkg::FRAC_BITS) / mi;
        mean = (ne + ni) >> 1;
        r.c.elc = relax_species(c.elc, mass_density(mean, me));
        r.c.ion = relax_species(c.ion, mass_density(mean, mi));
        r.bad = 1'b0;
        return r;
    endfunction

    task automatic write_reg(logic [tfdr_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[DW-2:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tfdr_pkg::REG_ELC_MASS: elc_mass_q = val & UMAX;
            tfdr_pkg::REG_ION_MASS: ion_mass_q = val & UMAX;
            // The adiabatic index has no effect on the result.
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Sends one cell; the expected result is queued when the beat is taken.
    // Valid stays high between cells unless a random gap is put in; the caller drops it after the last one.
    task automatic send_cell(t_cell c, bit typed, t_relaxed want);
        int gap;
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        cell_in <= c;
        do @(posedge i_clk); while (!o_in_ready);
        pending_cells.push_back(typed ? want : relax_cell(c));
        beats_in++;
    endtask

    function automatic t_species rand_species(int shape);
        t_species s;
        case (shape)
            0: begin
                s.rho = (DW-1)'($urandom_range(1, 32'h7FFF_FFFF));
                s.mx = $urandom;
                s.my = $urandom;
                s.mz = $urandom;
                s.en = (DW-1)'($urandom);
            end
            default: begin
                // Physically sized cells: modest momenta, energy anywhere in its range.
                s.rho = (DW-1)'($urandom_range(32'h0000_4000, 32'h0040_0000));
                s.mx = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                s.my = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                s.mz = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                s.en = (DW-1)'($urandom_range(0, 32'h7FFF_FFFF));
            end
        endcase
        return s;
    endfunction

    task automatic random_phase(int count);
        t_cell c;
        t_relaxed none;
        none = '0;
        for (int k = 0; k < count; k++) begin
            c.elc = rand_species($urandom_range(0, 3));
            c.ion = rand_species($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) c.elc.rho = '0;
            if ($urandom_range(0, 19) == 0) c.ion.rho = '0;
            send_cell(c, 1'b0, none);
        end
        i_in_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off while input fills.
    always @(posedge i_clk) begin
        if (long_hold || (!idle_off && $urandom_range(0, 3) == 0))
            i_out_ready <= 1'b0;
        else
            i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_relaxed want;
            beats_out++;
            if (o_bad_density) bad_seen++;
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                want = pending_cells.pop_front();
                if (cell_out !== want.c || o_bad_density !== want.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h bad %b, got %h bad %b",
                                 want.c, want.bad, cell_out, o_bad_density);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("two_fluid_density_relax test failed");
            $finish;
        end
    end

    typedef struct {
        t_cell    c;
        bit       typed;
        t_relaxed want;
    } t_row;

    t_row rows[$];

    function automatic t_row mk(t_cell c, bit typed, t_relaxed w);
        t_row r;
        r.c = c;
        r.typed = typed;
        r.want = w;
        return r;
    endfunction

    function automatic t_species sp(longint r, longint x, longint y, longint z,
                                    longint e);
        t_species s;
        s.rho = r[DW-2:0];
        s.mx = x[DW-1:0];
        s.my = y[DW-1:0];
        s.mz = z[DW-1:0];
        s.en = e[DW-2:0];
        return s;
    endfunction

    initial begin
        t_cell c;
        t_relaxed w;
        int hold;
        elc_mass_q = tfdr_pkg::ELC_MASS_RST;
        ion_mass_q = tfdr_pkg::ION_MASS_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero densities pass through with the flag; the remaining rows are
        // predicted under the reset masses.
        c.elc = sp(0, SMIN, SMAX, -1, UMAX);
        c.ion = sp(5, 1, 2, 3, 4);
        w.c = c; w.bad = 1'b1;
        rows.push_back(mk(c, 1, w));
        c.elc = sp(7, 0, 0, 0, 0);
        c.ion = sp(0, SMAX, SMIN, 0, 0);
        w.c = c; w.bad = 1'b1;
        rows.push_back(mk(c, 1, w));
        c.elc = sp(0, 0, 0, 0, 0);
        c.ion = sp(0, 0, 0, 0, 0);
        w.c = c; w.bad = 1'b1;
        rows.push_back(mk(c, 1, w));
        c.elc = sp(UMAX, SMAX, SMIN, SMIN, UMAX);
        c.ion = sp(UMAX, SMIN, SMAX, SMAX, UMAX);
        rows.push_back(mk(c, 0, w));
        c.elc = sp(1, SMIN, SMIN, SMIN, 0);
        c.ion = sp(UMAX, 1, -1, 0, UMAX);
        rows.push_back(mk(c, 0, w));
        c.elc = sp(65536, 65536, 0, 0, 0);
        c.ion = sp(1, 0, 0, 0, 0);
        rows.push_back(mk(c, 0, w));
        c.elc = sp(1, 1, 1, 1, 1);
        c.ion = sp(1, -1, -1, -1, 1);
        rows.push_back(mk(c, 0, w));
        c.elc = sp(2621, 2621, -2621, 100, 99999);
        c.ion = sp(65536, 65536, 0, -65536, 200000);
        rows.push_back(mk(c, 0, w));
        foreach (rows[k]) send_cell(rows[k].c, rows[k].typed, rows[k].want);
        i_in_valid <= 1'b0;
        drain();

        // Unit masses make a zero-flagged-free cell with equal densities exact.
        write_reg(tfdr_pkg::REG_ELC_MASS, 65536);
        write_reg(tfdr_pkg::REG_ION_MASS, 65536);
        write_reg(tfdr_pkg::REG_GAS_GAMMA, 65537);
        c.elc = sp(65536, 65536, -65536, 0, 65536);
        c.ion = sp(65536, 0, 0, 0, 0);
        w.c = c; w.bad = 1'b0;
        send_cell(c, 1, w);
        random_phase(80);
        drain();

        // Extreme masses: zero is read as one, all ones saturates densities.
        write_reg(tfdr_pkg::REG_ELC_MASS, 0);
        write_reg(tfdr_pkg::REG_ION_MASS, UMAX);
        write_reg(tfdr_pkg::REG_GAS_GAMMA, UMAX);
        random_phase(50);
        drain();

        write_reg(tfdr_pkg::REG_ELC_MASS, 1);
        write_reg(tfdr_pkg::REG_ION_MASS, 1);
        random_phase(30);

        // Hold results back long enough to back up the pipeline.
        long_hold = 1;
        fork
            random_phase(200);
            begin
                hold = 0;
                while (hold < LATENCY + 300) begin
                    @(posedge i_clk);
                    hold++;
                end
                long_hold = 0;
            end
        join
        // Sender waits for the pipeline to empty completely.
        while (pending_cells.size() != 0) @(posedge i_clk);
        drain();

        write_reg(tfdr_pkg::REG_ELC_MASS, $urandom_range(1, 32'h7FFF_FFFF));
        write_reg(tfdr_pkg::REG_ION_MASS, $urandom_range(1, 32'h7FFF_FFFF));
        write_reg(tfdr_pkg::REG_GAS_GAMMA, $urandom_range(65537, 32'h7FFF_FFFF));
        random_phase(60);
        drain();

        write_reg(tfdr_pkg::REG_ELC_MASS, tfdr_pkg::ELC_MASS_RST);
        write_reg(tfdr_pkg::REG_ION_MASS, tfdr_pkg::ION_MASS_RST);
        idle_off = 1;
        random_phase(70);

        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Sent %0d cells and checked %0d results, %0d of them flagged,",
                 beats_in, beats_out, bad_seen);
        $display("over six mass settings with idling, a long stall and a drain.");
        if (mismatches == 0 && pending_cells.size() == 0) begin
            $display("two_fluid_density_relax test passed");
        end else begin
            $display("two_fluid_density_relax test failed");
        end
        $finish;
    end

endmodule
